@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mtx4_pkg.sv @@
// Shared types and constants for the 4x4 matrix row multiplier.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mtx4_pkg;

	localparam int unsigned DATA_W            = 32;
	localparam int unsigned DIM               = 4;
	localparam int unsigned ROW_W             = 2;
	localparam int unsigned FRAC_BITS_DEFAULT = 16;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_MUL  = 1'b1
	} kind_t;

	// Request payload as seen on the input channel.
	typedef struct packed {
		kind_t                    kind;
		logic [ROW_W-1:0]         row;
		logic signed [DATA_W-1:0] elem0;
		logic signed [DATA_W-1:0] elem1;
		logic signed [DATA_W-1:0] elem2;
		logic signed [DATA_W-1:0] elem3;
	} req_t;

	// Result payload as seen on the output channel.
	typedef struct packed {
		logic [ROW_W-1:0]         out_row;
		logic signed [DATA_W-1:0] prod0;
		logic signed [DATA_W-1:0] prod1;
		logic signed [DATA_W-1:0] prod2;
		logic signed [DATA_W-1:0] prod3;
	} rsp_t;

	// Decoded operation passed from front to back through the queue.
	typedef struct packed {
		kind_t            kind;
		logic [ROW_W-1:0] row;
		word_t [DIM-1:0]  elem;
	} op_t;

endpackage

@@ src/matrix4_row_multiply.sv @@
// 4x4 fixed-point matrix row multiplier, top level.
// Instantiates mtx4_front, mtx4_queue, mtx4_back; depends on mtx4_pkg, assert_macros.svh.
//
// Usage:
//   req channel (req_valid / req_ready / req): a load item (kind = load)
//   writes row "row" of the stored matrix A and returns nothing; a multiply
//   item carries row "row" of B and returns product row C[row][j] =
//   sum over k of B[row][k] * A[k][j], signed fixed point with FRAC_BITS
//   fraction bits, each term floored, each sum saturated to 32 bits.
//   rsp channel (rsp_valid / rsp_ready / rsp): one transfer per multiply,
//   in request order.
// Pipeline: a multiply passes through the front register, the queue, the
//   multiply stage, the pair-add stage, and the final add and saturate
//   into the output register before rsp_valid rises.
// Throughput: one request per cycle while rsp_ready is high, loads and multiplies alike; set by the
//   sixteen parallel 32x32 multipliers that take a whole row at once.
// Reset: arst_n clears the stored matrix to zero and empties all stages.
// Stall: while rsp_ready is low the result holds in the output register,
//   the pipeline and queue keep filling, and req_ready drops once the
//   queue and front register are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix4_row_multiply #(
	parameter int unsigned FRAC_BITS   = mtx4_pkg::FRAC_BITS_DEFAULT,
	parameter int unsigned QUEUE_DEPTH = mtx4_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mtx4_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mtx4_pkg::rsp_t rsp
);

	// multiplies in flight: front register, queue, three back stages
	localparam int unsigned PEND_W = $clog2(QUEUE_DEPTH + 5);

	logic          fr_valid;
	logic          fr_ready;
	mtx4_pkg::op_t fr_op;
	logic          bk_valid;
	logic          bk_ready;
	mtx4_pkg::op_t bk_op;

	logic [PEND_W-1:0] mul_pending_q;
	logic              mul_in;
	logic              rsp_out;

	mtx4_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.op_valid  (fr_valid),
		.op_ready  (fr_ready),
		.op        (fr_op)
	);

	mtx4_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_op     (fr_op),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_op    (bk_op)
	);

	mtx4_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (bk_valid),
		.op_ready  (bk_ready),
		.op        (bk_op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	assign mul_in  = req_valid && req_ready && (req.kind == mtx4_pkg::KIND_MUL);
	assign rsp_out = rsp_valid && rsp_ready;

	// track multiplies accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_pending_q <= '0;
		end else if (mul_in && !rsp_out) begin
			mul_pending_q <= mul_pending_q + 1'b1;
		end else if (rsp_out && !mul_in) begin
			mul_pending_q <= mul_pending_q - 1'b1;
		end
	end

	`ASSERT_IMPLIES(a_rsp_from_mul, clk, arst_n, rsp_valid, mul_pending_q != '0, "stray result")
	`ASSERT_NEXT(a_mul_tracked, clk, arst_n, mul_in, mul_pending_q != '0, "multiply lost")
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !req_ready, fr_valid, "stall, front empty")

endmodule

@@ src/mtx4_front.sv @@
// Front stage: takes request transfers, decodes them into queue operations.
// Depends on mtx4_pkg.
`timescale 1ns / 1ps

module mtx4_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mtx4_pkg::req_t req,
	output logic           op_valid,
	input  logic           op_ready,
	output mtx4_pkg::op_t  op
);

	logic          v_s1;
	mtx4_pkg::op_t op_s1;

	// take a new request when empty or whenever the held one leaves this cycle
	assign req_ready = !v_s1 || op_ready;
	assign op_valid  = v_s1;
	assign op        = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ready) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_s1.kind    <= req.kind;
			op_s1.row     <= req.row;
			op_s1.elem[0] <= req.elem0;
			op_s1.elem[1] <= req.elem1;
			op_s1.elem[2] <= req.elem2;
			op_s1.elem[3] <= req.elem3;
		end
	end

endmodule

@@ src/mtx4_queue.sv @@
// Short FIFO of decoded operations between the front and back stages.
// Depends on mtx4_pkg.
`timescale 1ns / 1ps

module mtx4_queue #(
	parameter int unsigned DEPTH = mtx4_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mtx4_pkg::op_t in_op,
	output logic          out_valid,
	input  logic          out_ready,
	output mtx4_pkg::op_t out_op
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	mtx4_pkg::op_t    mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != FULL;
	assign out_valid = count_q != '0;
	assign out_op    = mem[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= in_op;
		end
	end

endmodule

@@ src/mtx4_back.sv @@
// Back end: holds the right-hand matrix A, applies row loads and runs the
// multiply / pair-add / final-add-and-saturate pipeline. Depends on mtx4_pkg.
`timescale 1ns / 1ps

module mtx4_back #(
	parameter int unsigned FRAC_BITS = mtx4_pkg::FRAC_BITS_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_ready,
	input  mtx4_pkg::op_t  op,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mtx4_pkg::rsp_t rsp
);

	localparam int unsigned DW     = mtx4_pkg::DATA_W;
	localparam int unsigned N      = mtx4_pkg::DIM;
	localparam int unsigned PROD_W = 2 * DW;
	localparam int unsigned TERM_W = PROD_W - FRAC_BITS;
	localparam int unsigned PAIR_W = TERM_W + 1;
	localparam int unsigned SUM_W  = TERM_W + 2;

	mtx4_pkg::word_t a_q [N][N];

	logic                          v_s1;
	logic [mtx4_pkg::ROW_W-1:0]    row_s1;
	logic signed [TERM_W-1:0]      term_s1 [N][N];
	logic                          v_s2;
	logic [mtx4_pkg::ROW_W-1:0]    row_s2;
	logic signed [PAIR_W-1:0]      pair_s2 [N][2];
	logic                          rsp_valid_q;
	logic [mtx4_pkg::ROW_W-1:0]    out_row_q;
	mtx4_pkg::word_t               prod_q [N];

	logic signed [PROD_W-1:0]      prod_full [N][N];
	mtx4_pkg::word_t               sat [N];
	logic                          out_free;
	logic                          s2_free;
	logic                          s1_free;
	logic                          pop;
	logic                          do_load;
	logic                          do_mul;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign s2_free  = !v_s2 || out_free;
	assign s1_free  = !v_s1 || s2_free;
	// loads retire at the queue head; multiplies need room in the pipeline
	assign op_ready = (op.kind == mtx4_pkg::KIND_LOAD) || s1_free;
	assign pop      = op_valid && op_ready;
	assign do_load  = pop && (op.kind == mtx4_pkg::KIND_LOAD);
	assign do_mul   = pop && (op.kind == mtx4_pkg::KIND_MUL);

	// element j of the result row: sum over k of B[k] * A[k][j]
	always_comb begin
		for (int j = 0; j < N; j++) begin
			for (int k = 0; k < N; k++) begin
				prod_full[j][k] = signed'(a_q[k][j]) * signed'(op.elem[k]);
			end
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0]  sum;
		logic [SUM_W-DW:0]        hi;
		for (int j = 0; j < N; j++) begin
			sum = SUM_W'(pair_s2[j][0]) + SUM_W'(pair_s2[j][1]);
			hi  = sum[SUM_W-1:DW-1];
			priority if (&hi || ~|hi) begin
				sat[j] = sum[DW-1:0];
			end else if (sum[SUM_W-1]) begin
				sat[j] = {1'b1, {(DW-1){1'b0}}};
			end else begin
				sat[j] = {1'b0, {(DW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < N; r++) begin
				for (int c = 0; c < N; c++) begin
					a_q[r][c] <= '0;
				end
			end
		end else if (do_load) begin
			for (int c = 0; c < N; c++) begin
				a_q[op.row][c] <= op.elem[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= do_mul;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				rsp_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_mul) begin
			row_s1 <= op.row;
			for (int j = 0; j < N; j++) begin
				for (int k = 0; k < N; k++) begin
					term_s1[j][k] <= TERM_W'(prod_full[j][k] >>> FRAC_BITS);
				end
			end
		end
		if (v_s1 && s2_free) begin
			row_s2 <= row_s1;
			for (int j = 0; j < N; j++) begin
				pair_s2[j][0] <= PAIR_W'(term_s1[j][0]) + PAIR_W'(term_s1[j][1]);
				pair_s2[j][1] <= PAIR_W'(term_s1[j][2]) + PAIR_W'(term_s1[j][3]);
			end
		end
		if (v_s2 && out_free) begin
			out_row_q <= row_s2;
			for (int j = 0; j < N; j++) begin
				prod_q[j] <= sat[j];
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp.out_row   = out_row_q;
	assign rsp.prod0     = prod_q[0];
	assign rsp.prod1     = prod_q[1];
	assign rsp.prod2     = prod_q[2];
	assign rsp.prod3     = prod_q[3];

endmodule

@@ tb/matrix4_row_multiply_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for matrix4_row_multiply: directed and random row loads and
// multiplies, checked against an in-bench Q16.16 product predictor.
// Depends on mtx4_pkg and the matrix4_row_multiply RTL.

module matrix4_row_multiply_tb;

	localparam int FRAC_BITS     = mtx4_pkg::FRAC_BITS_DEFAULT;
	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int STALL_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_MAX    = 10;

	localparam mtx4_pkg::word_t W_MAX    = 32'h7FFF_FFFF;
	localparam mtx4_pkg::word_t W_MIN    = 32'h8000_0000;
	localparam mtx4_pkg::word_t W_NEG1   = 32'hFFFF_FFFF;
	localparam mtx4_pkg::word_t W_ONE    = 32'h0001_0000;
	localparam mtx4_pkg::word_t W_NEGONE = 32'hFFFF_0000;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	mtx4_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	mtx4_pkg::rsp_t rsp;

	mtx4_pkg::word_t matrix_a [16];
	mtx4_pkg::rsp_t  expected_rows [$];
	int    mismatches;
	int    loads_sent;
	int    muls_sent;
	int    rows_checked;
	int    idle_cycles;
	int    stall_left;
	bit    sender_idling;
	bit    receiver_idling;

	matrix4_row_multiply #(
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Row of C: each exact term floored by the fraction shift, only the sum saturated.
	function automatic mtx4_pkg::rsp_t predict_row(input mtx4_pkg::req_t item);
		mtx4_pkg::rsp_t  r;
		mtx4_pkg::word_t b_row [4];
		mtx4_pkg::word_t c_row [4];
		longint acc;
		longint term;
		b_row[0] = item.elem0;
		b_row[1] = item.elem1;
		b_row[2] = item.elem2;
		b_row[3] = item.elem3;
		for (int j = 0; j < 4; j++) begin
			acc = 0;
			for (int k = 0; k < 4; k++) begin
				term = longint'(matrix_a[k * 4 + j]) * longint'(b_row[k]);
				acc += term >>> FRAC_BITS;
			end
			if (acc > longint'(W_MAX))
				c_row[j] = W_MAX;
			else if (acc < longint'(W_MIN))
				c_row[j] = W_MIN;
			else
				c_row[j] = mtx4_pkg::word_t'(acc);
		end
		r.out_row = item.row;
		r.prod0   = c_row[0];
		r.prod1   = c_row[1];
		r.prod2   = c_row[2];
		r.prod3   = c_row[3];
		return r;
	endfunction

	function automatic mtx4_pkg::word_t random_word();
		mtx4_pkg::word_t w;
		case ($urandom_range(0, 9))
			0, 1, 2: w = $urandom;
			3, 4, 5, 6, 7:
				w = mtx4_pkg::word_t'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			default: begin
				case ($urandom_range(0, 6))
					0: w = W_MAX;
					1: w = W_MIN;
					2: w = W_NEG1;
					3: w = W_ONE;
					4: w = W_NEGONE;
					5: w = 32'sd1;
					default: w = '0;
				endcase
			end
		endcase
		return w;
	endfunction

	function automatic mtx4_pkg::req_t random_item();
		mtx4_pkg::req_t item;
		item.kind  = ($urandom_range(0, 99) < 35) ? mtx4_pkg::KIND_LOAD : mtx4_pkg::KIND_MUL;
		item.row   = 2'($urandom_range(0, 3));
		item.elem0 = random_word();
		item.elem1 = random_word();
		item.elem2 = random_word();
		item.elem3 = random_word();
		return item;
	endfunction

	// Call at a rising edge; returns at the edge where the item transfers.
	task automatic send_item(input mtx4_pkg::req_t item);
		if (sender_idling && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		if (item.kind == mtx4_pkg::KIND_LOAD) begin
			matrix_a[item.row * 4 + 0] = item.elem0;
			matrix_a[item.row * 4 + 1] = item.elem1;
			matrix_a[item.row * 4 + 2] = item.elem2;
			matrix_a[item.row * 4 + 3] = item.elem3;
			loads_sent++;
		end else begin
			expected_rows.push_back(predict_row(item));
			muls_sent++;
		end
	endtask

	task automatic send_row(input mtx4_pkg::kind_t kind,
			input logic [mtx4_pkg::ROW_W-1:0] row,
			input mtx4_pkg::word_t e0, input mtx4_pkg::word_t e1,
			input mtx4_pkg::word_t e2, input mtx4_pkg::word_t e3);
		mtx4_pkg::req_t item;
		item = '{kind: kind, row: row, elem0: e0, elem1: e1, elem2: e2, elem3: e3};
		send_item(item);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_item(random_item());
	endtask

	// Hold off the sender until every pending product row has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_rows.size() != 0);
	endtask

	task automatic test_zero_matrix();
		send_row(mtx4_pkg::KIND_MUL, 2'd2, W_MAX, W_MIN, W_MAX, W_MIN);
		send_row(mtx4_pkg::KIND_MUL, 2'd3, W_NEG1, W_NEG1, W_NEG1, W_NEG1);
	endtask

	task automatic test_identity();
		send_row(mtx4_pkg::KIND_LOAD, 2'd0, W_ONE, '0, '0, '0);
		send_row(mtx4_pkg::KIND_LOAD, 2'd1, '0, W_ONE, '0, '0);
		send_row(mtx4_pkg::KIND_LOAD, 2'd2, '0, '0, W_ONE, '0);
		send_row(mtx4_pkg::KIND_LOAD, 2'd3, '0, '0, '0, W_ONE);
		send_row(mtx4_pkg::KIND_MUL, 2'd0, W_MIN, W_MAX, '0, W_NEG1);
		send_row(mtx4_pkg::KIND_MUL, 2'd1, W_MAX, W_MIN, 32'sd1, W_ONE);
		send_row(mtx4_pkg::KIND_MUL, 2'd2, '0, W_NEG1, W_MIN, W_MAX);
		send_row(mtx4_pkg::KIND_MUL, 2'd3, 32'sd1, '0, W_MAX, W_MIN);
	endtask

	task automatic test_saturation();
		send_row(mtx4_pkg::KIND_LOAD, 2'd0, W_MAX, W_MAX, W_MAX, W_MAX);
		send_row(mtx4_pkg::KIND_LOAD, 2'd1, W_MIN, W_MIN, W_MIN, W_MIN);
		send_row(mtx4_pkg::KIND_LOAD, 2'd2, W_MAX, W_MAX, W_MAX, W_MAX);
		send_row(mtx4_pkg::KIND_LOAD, 2'd3, W_MIN, W_MIN, W_MIN, W_MIN);
		send_row(mtx4_pkg::KIND_MUL, 2'd0, W_MAX, '0, W_MAX, '0);
		send_row(mtx4_pkg::KIND_MUL, 2'd1, '0, W_MAX, '0, '0);
		// huge terms of opposite sign cancel to a sum inside the range
		send_row(mtx4_pkg::KIND_MUL, 2'd2, W_MAX, W_MAX, '0, '0);
	endtask

	task automatic test_floor_rounding();
		send_row(mtx4_pkg::KIND_LOAD, 2'd0, W_NEG1, 32'sd1, W_NEG1, 32'sd1);
		send_row(mtx4_pkg::KIND_MUL, 2'd1, 32'sd1, '0, '0, '0);
		send_row(mtx4_pkg::KIND_MUL, 2'd3, W_NEG1, '0, '0, '0);
	endtask

	task automatic test_mixed_traffic();
		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		send_random(700);
	endtask

	task automatic test_backpressure();
		sender_idling   = 1'b0;
		receiver_idling = 1'b1;
		send_random(400);
		wait_drained();
	endtask

	task automatic test_full_rate();
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		send_random(330);
	endtask

	task automatic compare_field(input string field,
			input logic [mtx4_pkg::DATA_W-1:0] want,
			input logic [mtx4_pkg::DATA_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		mtx4_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected result transfer, row %0d", $realtime, rsp.out_row);
			end else begin
				want = expected_rows.pop_front();
				compare_field("out_row", mtx4_pkg::DATA_W'(want.out_row),
					mtx4_pkg::DATA_W'(rsp.out_row));
				compare_field("prod0", want.prod0, rsp.prod0);
				compare_field("prod1", want.prod1, rsp.prod1);
				compare_field("prod2", want.prod2, rsp.prod2);
				compare_field("prod3", want.prod3, rsp.prod3);
				rows_checked++;
			end
		end
	end

	// Drop ready in random bursts while receiver idling is on.
	initial begin
		rsp_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (receiver_idling && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 17);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		mismatches      = 0;
		loads_sent      = 0;
		muls_sent       = 0;
		rows_checked    = 0;
		idle_cycles     = 0;
		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		foreach (matrix_a[i])
			matrix_a[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_matrix();
		test_identity();
		test_saturation();
		test_floor_rounding();
		test_mixed_traffic();
		test_backpressure();
		test_full_rate();

		req_valid <= 1'b0;
		do @(posedge clk); while (expected_rows.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d row loads and %0d multiplies; checked %0d product rows,",
			loads_sent, muls_sent, rows_checked);
		$display("Covered zero matrix, identity, saturation both ways, floor rounding, stalls; %0d mismatches.",
			mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
